// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the checker file ars_chk.sv.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/ars_pkg.sv -----
// ---------------------------------------------------------------------------
// ars_pkg
// Types and constants shared by the analog range scaler modules.
// ---------------------------------------------------------------------------
package ars_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FW_W       = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SECOND = 2'd2;

  localparam logic [FW_W-1:0]       FIELD_WIDTH_RST  = 6'd8;
  localparam logic [CFG_DATA_W-1:0] RANGE_FIRST_RST  = 32'd0;
  localparam logic [CFG_DATA_W-1:0] RANGE_SECOND_RST = 32'd255;

  // Datapath
  localparam int SAMPLE_W   = 32;
  localparam int SPAN_W     = 32;
  localparam int COUNT_W    = SPAN_W + 1;
  localparam int LEVEL_W    = 8;
  localparam int DIV_BITS   = 2;                   // quotient bits per stage
  localparam int DIV_STAGES = LEVEL_W / DIV_BITS;

  localparam logic [LEVEL_W-1:0] CENTER_FLIP = 8'h80;

  // Values derived from the configuration registers
  typedef struct packed {
    logic                       rev;    // range given high to low
    logic signed [SAMPLE_W-1:0] lo;     // range minimum
    logic                       sext;   // sign-extend from field width
    logic [4:0]                 sh;     // 32 - field width
    logic [SPAN_W-1:0]          span;   // max - min
    logic [COUNT_W-1:0]         count;  // max - min + 1
    logic                       full;   // range covers all 2^32 values
  } cfg_t;

  // Divider stage payload
  typedef struct packed {
    logic [SPAN_W-1:0]  rem;
    logic [LEVEL_W-1:0] q;
  } div_t;

endpackage

// ----- hw/rtl/ars_cfg.sv -----
// ---------------------------------------------------------------------------
// ars_cfg
// Configuration registers and the range values derived from them.
// ---------------------------------------------------------------------------
module ars_cfg import ars_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_o
);

  logic [FW_W-1:0]       field_width_r;
  logic [CFG_DATA_W-1:0] range_first_r;
  logic [CFG_DATA_W-1:0] range_second_r;

  logic                       rev_nxt, rev_r;
  logic signed [SAMPLE_W-1:0] lo_nxt, lo_r, hi_nxt, hi_r;
  logic                       sext_nxt, sext_r;
  logic [4:0]                 sh_nxt, sh_r;
  logic [SPAN_W:0]            diff_w;
  logic [SPAN_W-1:0]          span_nxt, span_r;
  logic [COUNT_W-1:0]         count_nxt, count_r;
  logic                       full_nxt, full_r;

  // Write registers; unknown index drops the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r  <= FIELD_WIDTH_RST;
      range_first_r  <= RANGE_FIRST_RST;
      range_second_r <= RANGE_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIELD_WIDTH:  field_width_r  <= cfg_wdata[FW_W-1:0];
        REG_RANGE_FIRST:  range_first_r  <= cfg_wdata;
        REG_RANGE_SECOND: range_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Order the bounds, decide on sign extension
  always_comb begin
    rev_nxt  = $signed(range_first_r) > $signed(range_second_r);
    lo_nxt   = rev_nxt ? $signed(range_second_r) : $signed(range_first_r);
    hi_nxt   = rev_nxt ? $signed(range_first_r) : $signed(range_second_r);
    sext_nxt = lo_nxt[SAMPLE_W-1] && (field_width_r != '0) &&
               (field_width_r < FW_W'(SAMPLE_W));
    sh_nxt   = 5'(FW_W'(SAMPLE_W) - field_width_r);
  end

  always_ff @(posedge clk) begin
    rev_r  <= rev_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    sext_r <= sext_nxt;
    sh_r   <= sh_nxt;
  end

  // Span and divisor, registered in the cycle after the ordered bounds
  always_comb begin
    diff_w    = (SPAN_W+1)'(hi_r) - (SPAN_W+1)'(lo_r);
    span_nxt  = diff_w[SPAN_W-1:0];
    count_nxt = {1'b0, span_nxt} + COUNT_W'(1);
    full_nxt  = &span_nxt;
  end

  always_ff @(posedge clk) begin
    span_r  <= span_nxt;
    count_r <= count_nxt;
    full_r  <= full_nxt;
  end

  assign cfg_o.rev   = rev_r;
  assign cfg_o.lo    = lo_r;
  assign cfg_o.sext  = sext_r;
  assign cfg_o.sh    = sh_r;
  assign cfg_o.span  = span_r;
  assign cfg_o.count = count_r;
  assign cfg_o.full  = full_r;

endmodule

// ----- hw/rtl/ars_front.sv -----
// ---------------------------------------------------------------------------
// ars_front
// Input register, sign extension and offset, then mirror and clamp.
// ---------------------------------------------------------------------------
module ars_front import ars_pkg::*; #(
  parameter int RAW_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg_i,
  input  logic                in_vld,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_raw,
  output logic                out_vld,
  input  logic                out_stall,
  output div_t                out_data
);

  localparam int T_W = SAMPLE_W + 2;
  localparam int D_W = SAMPLE_W + 3;

  logic                 s0_vld_r, s1_vld_r, s2_vld_r;
  logic                 s0_stall, s1_stall, s2_stall;
  logic [RAW_WIDTH-1:0] raw_r;

  logic [SAMPLE_W-1:0]        raw32_w, shl_w;
  logic signed [SAMPLE_W-1:0] ext_w;
  logic signed [T_W-1:0]      t_nxt, t_r;
  logic signed [D_W-1:0]      d0_w;
  logic [SPAN_W-1:0]          d_nxt, d_r;

  // Stall chain, one stage at a time
  assign s2_stall = s2_vld_r && out_stall;
  assign s1_stall = s1_vld_r && s2_stall;
  assign s0_stall = s0_vld_r && s1_stall;
  assign in_stall = s0_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (!s0_stall) s0_vld_r <= in_vld;
      if (!s1_stall) s1_vld_r <= s0_vld_r;
      if (!s2_stall) s2_vld_r <= s1_vld_r;
    end
  end

  // Stage 0: capture the used bits of the request
  always_ff @(posedge clk) begin
    if (!s0_stall && in_vld) raw_r <= in_raw[RAW_WIDTH-1:0];
  end

  // Stage 1: sign-extend from the field width, take offset from minimum
  always_comb begin
    raw32_w = SAMPLE_W'(raw_r);
    shl_w   = raw32_w << cfg_i.sh;
    ext_w   = cfg_i.sext ? ($signed(shl_w) >>> cfg_i.sh) : $signed(raw32_w);
    t_nxt   = T_W'(ext_w) - T_W'(cfg_i.lo);
  end

  always_ff @(posedge clk) begin
    if (!s1_stall && s0_vld_r) t_r <= t_nxt;
  end

  // Stage 2: mirror a reversed range, clamp into [0, span]
  always_comb begin
    d0_w = cfg_i.rev ? ($signed(D_W'(cfg_i.span)) - D_W'(t_r)) : D_W'(t_r);
    if (d0_w[D_W-1])
      d_nxt = '0;
    else if (d0_w > $signed(D_W'(cfg_i.span)))
      d_nxt = cfg_i.span;
    else
      d_nxt = d0_w[SPAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!s2_stall && s1_vld_r) d_r <= d_nxt;
  end

  assign out_vld      = s2_vld_r;
  assign out_data.rem = d_r;
  assign out_data.q   = '0;

endmodule

// ----- hw/rtl/ars_div_stage.sv -----
// ---------------------------------------------------------------------------
// ars_div_stage
// One stage of the restoring divider: DIV_BITS quotient bits per stage.
// ---------------------------------------------------------------------------
module ars_div_stage import ars_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] count,
  input  logic               in_vld,
  output logic               in_stall,
  input  div_t               in_data,
  output logic               out_vld,
  input  logic               out_stall,
  output div_t               out_data
);

  logic               vld_r;
  div_t               data_nxt, data_r;
  logic [COUNT_W-1:0] rem_w;
  logic [LEVEL_W-1:0] q_w;
  logic               ge_w;

  assign in_stall = vld_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (!in_stall) vld_r <= in_vld;
  end

  // Shift in DIV_BITS remainder bits one at a time, subtract when it fits
  always_comb begin
    rem_w = {1'b0, in_data.rem};
    q_w   = in_data.q;
    ge_w  = 1'b0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_w = {rem_w[COUNT_W-2:0], 1'b0};
      ge_w  = rem_w >= count;
      if (ge_w) rem_w = rem_w - count;
      q_w   = {q_w[LEVEL_W-2:0], ge_w};
    end
    data_nxt.rem = rem_w[SPAN_W-1:0];
    data_nxt.q   = q_w;
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_vld) data_r <= data_nxt;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ----- hw/rtl/analog_range_scaler.sv -----
// ---------------------------------------------------------------------------
// analog_range_scaler
// Scales a raw analog sample onto an 8-bit level over a configured range.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_raw_sample; only its low
//   RAW_WIDTH bits are used. Output channel out_valid/out_stall carries
//   out_level (0..255) and out_centered_level (level - 128).
//   Configuration: cfg_we with cfg_index 0 = field_width, 1 = range_first,
//   2 = range_second; other indexes are dropped. Write only while idle.
// Pipeline:
//   A request passes through the input register, sign extension and
//   offset, mirror and clamp, then four divider stages of two quotient
//   bits each. One request per cycle is accepted while in_stall is low.
// Reset:
//   Synchronous, active low. Clears all stage valids and loads the
//   registers with field_width 8, range 0 to 255.
// Stall:
//   A stalled result holds. Stages behind it keep filling empty slots, so
//   in_stall rises only once every stage holds a request.
// ---------------------------------------------------------------------------
module analog_range_scaler import ars_pkg::*; #(
  parameter int RAW_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_W-1:0]       in_raw_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LEVEL_W-1:0]        out_level,
  output logic signed [LEVEL_W-1:0] out_centered_level,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

  cfg_t                  cfg_w;
  logic [DIV_STAGES:0]   div_vld;
  logic [DIV_STAGES:0]   div_stall;
  div_t                  div_data [0:DIV_STAGES];
  logic [LEVEL_W-1:0]    level_w;

  ars_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg_w)
  );

  ars_front #(
    .RAW_WIDTH (RAW_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg_w),
    .in_vld    (in_valid),
    .in_stall  (in_stall),
    .in_raw    (in_raw_sample),
    .out_vld   (div_vld[0]),
    .out_stall (div_stall[0]),
    .out_data  (div_data[0])
  );

  // Divider pipeline
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    ars_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .count     (cfg_w.count),
      .in_vld    (div_vld[k]),
      .in_stall  (div_stall[k]),
      .in_data   (div_data[k]),
      .out_vld   (div_vld[k+1]),
      .out_stall (div_stall[k+1]),
      .out_data  (div_data[k+1])
    );
  end

  assign div_stall[DIV_STAGES] = out_stall;

  // Full 2^32 span forces level zero
  assign level_w            = cfg_w.full ? '0 : div_data[DIV_STAGES].q;
  assign out_valid          = div_vld[DIV_STAGES];
  assign out_level          = level_w;
  assign out_centered_level = $signed(level_w ^ CENTER_FLIP);

endmodule

// ----- hw/rtl/ars_chk.sv -----
// ---------------------------------------------------------------------------
// ars_chk
// Port checker for the analog range scaler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ars_chk import ars_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [LEVEL_W-1:0]        out_level,
  input logic signed [LEVEL_W-1:0] out_centered_level
);

  // Stalled result holds its level
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_level), "stalled result changed")

  // Centered level is the level with the top bit flipped
  `ASSERT_CLK(a_centered, clk, rst_n, out_valid |-> (out_level[6:0] == out_centered_level[6:0]) && (out_level[7] != out_centered_level[7]), "centered level mismatch")

  // Input backs up only behind a stalled, full output
  `ASSERT_CLK(a_stall_src, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without output stall")

  // Reset empties the pipeline
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind analog_range_scaler ars_chk u_ars_chk (.*);

// ----- verif/analog_range_scaler_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// analog_range_scaler_test
// Self-checking bench for the analog range scaler. A directed table walks
// the reset range, full and reversed spans, and the sign-extension widths.
// Randomized phases follow: each loads a fresh range and runs samples under
// different sender gaps and receiver stalls, with one long output hold-off.
// Every result is compared with its typed table value or a bench-side scaling model.
// ---------------------------------------------------------------------------
module analog_range_scaler_test;
  import ars_pkg::*;

  localparam int RAW_W          = 32;
  localparam int LATENCY        = 7;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_REQUESTS = 75;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES    = 150;
  localparam int PRINT_CAP      = 40;
  localparam longint INT_TOP    = 64'sd2147483647;
  localparam longint INT_BOTTOM = -64'sd2147483648;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [SAMPLE_W-1:0]  RAW_MASK  = SAMPLE_W'((64'd1 << RAW_W) - 64'd1);

  // Gap and stall percentages per phase flavor
  localparam int SEND_GAP_PCT [4] = '{0, 75, 0, 36};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 75, 36};

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic [LEVEL_W-1:0]  level;
    logic [LEVEL_W-1:0]  centered;
  } level_expect_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    level_expect_t         want;
  } plan_row_t;

  logic                      clk                = 1'b0;
  logic                      rst_n              = 1'b0;
  logic                      in_valid           = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_W-1:0]       in_raw_sample      = '0;
  logic                      out_valid;
  logic                      out_stall          = 1'b0;
  logic [LEVEL_W-1:0]        out_level;
  logic signed [LEVEL_W-1:0] out_centered_level;
  logic                      cfg_we             = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index          = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata          = '0;

  // Bench copy of the configuration registers
  logic [FW_W-1:0]       field_width_q  = FIELD_WIDTH_RST;
  logic [CFG_DATA_W-1:0] range_first_q  = RANGE_FIRST_RST;
  logic [CFG_DATA_W-1:0] range_second_q = RANGE_SECOND_RST;

  level_expect_t pending_levels [$];

  int mismatches         = 0;
  int results_checked    = 0;
  int requests_sent      = 0;
  int register_writes    = 0;
  int input_stall_cycles = 0;
  int cycle_count        = 0;
  int gap_pct            = 0;
  int stall_pct          = 0;
  int hold_goal          = 0;
  int hold_done          = 0;

  analog_range_scaler #(
    .RAW_WIDTH(RAW_W)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_raw_sample     (in_raw_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level         (out_level),
    .out_centered_level(out_centered_level),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scale one raw sample over the current range, at 64 bits throughout.
  function automatic level_expect_t scale_sample(input logic [SAMPLE_W-1:0] raw_in);
    logic [SAMPLE_W-1:0] raw;
    longint first_v, second_v, lo_v, hi_v, v, span, count, quo;
    logic flip;
    level_expect_t res;
    raw      = raw_in & RAW_MASK;
    first_v  = longint'($signed(range_first_q));
    second_v = longint'($signed(range_second_q));
    flip     = first_v > second_v;
    lo_v     = flip ? second_v : first_v;
    hi_v     = flip ? first_v : second_v;
    // Sign-extend from the field width only for a negative minimum.
    if (lo_v < 0 && field_width_q >= 1 && field_width_q < 32) begin
      span = longint'(1) << field_width_q;
      v    = longint'(raw) & (span - 1);
      if ((v & (span >> 1)) != 0) v = v - span;
    end else begin
      v = longint'($signed(raw));
    end
    // Mirror a reversed range, then clamp.
    if (flip) v = hi_v + lo_v - v;
    if (v < lo_v) v = lo_v;
    if (v > hi_v) v = hi_v;
    count = hi_v - lo_v + 1;
    if (count >= (longint'(1) << 32)) quo = 0;
    else quo = ((v - lo_v) * 256) / count;
    res.raw      = raw_in;
    res.level    = quo[LEVEL_W-1:0];
    res.centered = res.level - 8'd128;
    return res;
  endfunction

  function automatic plan_row_t sample_row(input logic [SAMPLE_W-1:0] raw);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_SAMPLE;
    r.data = raw;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [SAMPLE_W-1:0] raw,
                                          input logic [LEVEL_W-1:0] lvl,
                                          input logic [LEVEL_W-1:0] ctr);
    plan_row_t r;
    r               = sample_row(raw);
    r.typed         = 1'b1;
    r.want.level    = lvl;
    r.want.centered = ctr;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] raw,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0d] MISMATCH %s for raw 0x%08h: got 0x%0h, want 0x%0h",
               cycle_count, what, raw, got, want);
  endtask

  // Offer one request, with random gaps ahead of it; queue its expectation
  // once taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input level_expect_t want);
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= raw;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    want.raw = raw;
    pending_levels.push_back(want);
    requests_sent++;
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_FIELD_WIDTH:  field_width_q  = data[FW_W-1:0];
      REG_RANGE_FIRST:  range_first_q  = data;
      REG_RANGE_SECOND: range_second_q = data;
      default: ;
    endcase
    register_writes++;
  endtask

  // Check each accepted result and pick the stall for the next cycle.
  always @(posedge clk) begin
    level_expect_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_levels.size() == 0) begin
          report_mismatch("result with nothing pending", '0, 32'(out_level), '0);
        end else begin
          want = pending_levels.pop_front();
          results_checked++;
          if (out_level !== want.level)
            report_mismatch("level", want.raw, 32'(out_level), 32'(want.level));
          if (out_centered_level !== want.centered)
            report_mismatch("centered_level", want.raw, 32'(out_centered_level),
                            32'(want.centered));
        end
      end
      if (hold_done < hold_goal) begin
        out_stall <= 1'b1;
        hold_done <= hold_done + 1;
      end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, pending_levels.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    logic writing;
    logic [CFG_DATA_W-1:0] fw_data;
    logic [SAMPLE_W-1:0] raw, noise, fmask;
    logic [63:0] offs;
    longint lo_pick, hi_pick, tmp, target;
    logic flip, ext_on;
    int fw_pick, flavor;

    plan = '{
      // Reset settings: width 8, range 0 to 255
      typed_row(32'h0000_0000, 8'h00, 8'h80),
      typed_row(32'h0000_00FF, 8'hFF, 8'h7F),
      typed_row(32'h0000_0080, 8'h80, 8'h00),
      typed_row(32'hFFFF_FFFF, 8'h00, 8'h80),
      typed_row(32'h7FFF_FFFF, 8'hFF, 8'h7F),
      write_row(REG_SPARE, 32'hFFFF_FFFF),
      typed_row(32'h0000_0040, 8'h40, 8'hC0),
      // Full 2^32 span gives zero
      write_row(REG_RANGE_FIRST, 32'h8000_0000),
      write_row(REG_RANGE_SECOND, 32'h7FFF_FFFF),
      typed_row(32'h0000_0000, 8'h00, 8'h80),
      typed_row(32'h8000_0000, 8'h00, 8'h80),
      // Signed byte range, extended from 8 bits
      write_row(REG_RANGE_FIRST, 32'hFFFF_FF80),
      write_row(REG_RANGE_SECOND, 32'h0000_007F),
      typed_row(32'h0000_0080, 8'h00, 8'h80),
      typed_row(32'h0000_007F, 8'hFF, 8'h7F),
      sample_row(32'hABCD_EF00),
      // Widths that leave the sample unextended
      write_row(REG_FIELD_WIDTH, 32'h0000_0000),
      sample_row(32'h0000_0080),
      write_row(REG_FIELD_WIDTH, 32'h0000_0020),
      sample_row(32'hFFFF_FF80),
      write_row(REG_FIELD_WIDTH, 32'hFFFF_FFFF),
      sample_row(32'h0000_0080),
      // One-bit field over -1 to 0
      write_row(REG_FIELD_WIDTH, 32'h0000_0001),
      write_row(REG_RANGE_FIRST, 32'hFFFF_FFFF),
      write_row(REG_RANGE_SECOND, 32'h0000_0000),
      sample_row(32'h0000_0001),
      sample_row(32'hFFFF_FFFE),
      // Reversed range 100 down to -100, 31-bit field
      write_row(REG_FIELD_WIDTH, 32'h0000_001F),
      write_row(REG_RANGE_FIRST, 32'h0000_0064),
      write_row(REG_RANGE_SECOND, 32'hFFFF_FF9C),
      sample_row(32'h7FFF_FFFF),
      sample_row(32'h4000_0000),
      sample_row(32'hBFFF_FFB0),
      // Single-value range with a non-negative minimum
      write_row(REG_FIELD_WIDTH, 32'h0000_0004),
      write_row(REG_RANGE_FIRST, 32'h0000_0005),
      write_row(REG_RANGE_SECOND, 32'h0000_0005),
      typed_row(32'h0000_0005, 8'h00, 8'h80),
      typed_row(32'h0000_000F, 8'h00, 8'h80),
      // Reversed full span, then a reversed half span
      write_row(REG_RANGE_FIRST, 32'h7FFF_FFFF),
      write_row(REG_RANGE_SECOND, 32'h8000_0000),
      typed_row(32'h1234_5678, 8'h00, 8'h80),
      write_row(REG_RANGE_SECOND, 32'h0000_0000),
      sample_row(32'h0000_0000),
      sample_row(32'hFFFF_FFFF)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) drain_results();
        write_reg(plan[i].idx, plan[i].data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        send_sample(plan[i].data,
                    plan[i].typed ? plan[i].want : scale_sample(plan[i].data));
      end
    end

    // Randomized phases, each with its own range and traffic pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      flip = 1'($urandom_range(1, 0));
      case (p)
        0: begin
          fw_pick = 32;
          lo_pick = INT_BOTTOM;
          hi_pick = INT_TOP;
        end
        1: begin
          fw_pick = 1;
          lo_pick = INT_BOTTOM + 1;
          hi_pick = INT_TOP;
          flip    = 1'b1;
        end
        2: begin
          fw_pick = 0;
          lo_pick = INT_BOTTOM;
          hi_pick = INT_BOTTOM + 255;
        end
        default: begin
          case ($urandom_range(7, 0))
            0:       fw_pick = 0;
            1:       fw_pick = 32;
            2:       fw_pick = $urandom_range(63, 33);
            default: fw_pick = $urandom_range(31, 1);
          endcase
          case ($urandom_range(3, 0))
            0: begin
              lo_pick = longint'($urandom_range(600, 0)) - 300;
              hi_pick = lo_pick + longint'($urandom_range(600, 0));
            end
            1: begin
              if (fw_pick >= 1 && fw_pick < 32) begin
                lo_pick = -(longint'(1) << (fw_pick - 1));
                hi_pick = -lo_pick - 1;
              end else begin
                lo_pick = -128;
                hi_pick = 127;
              end
            end
            2: begin
              lo_pick = longint'($signed($urandom()));
              hi_pick = lo_pick + longint'($urandom() >> $urandom_range(31, 0));
              if (hi_pick > INT_TOP) hi_pick = INT_TOP;
            end
            default: begin
              lo_pick = longint'($signed($urandom()));
              hi_pick = longint'($signed($urandom()));
              if (lo_pick > hi_pick) begin
                tmp     = lo_pick;
                lo_pick = hi_pick;
                hi_pick = tmp;
              end
            end
          endcase
        end
      endcase

      // Load the new settings while the block is empty
      fw_data = ($urandom() & ~32'h3F) | CFG_DATA_W'(fw_pick);
      drain_results();
      write_reg(REG_FIELD_WIDTH, fw_data);
      write_reg(REG_RANGE_FIRST, flip ? hi_pick[31:0] : lo_pick[31:0]);
      write_reg(REG_RANGE_SECOND, flip ? lo_pick[31:0] : hi_pick[31:0]);
      write_reg(REG_SPARE, $urandom());
      cfg_we <= 1'b0;

      ext_on = lo_pick < 0 && field_width_q >= 1 && field_width_q < 32;
      fmask  = SAMPLE_W'((64'd1 << field_width_q) - 64'd1);

      flavor = p % 4;
      if (p == PRESSURE_PHASE) begin
        // Hold the output off long enough for the pipe to back up
        gap_pct   = 0;
        stall_pct <= 0;
        hold_goal <= hold_goal + HOLD_CYCLES;
      end else begin
        gap_pct   = SEND_GAP_PCT[flavor];
        stall_pct <= RECV_STALL_PCT[flavor];
      end

      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        noise = $urandom();
        case ($urandom_range(7, 0))
          0, 1: raw = noise;
          2: begin
            target = ($urandom_range(1, 0) ? lo_pick : hi_pick)
                     + longint'($urandom_range(2, 0)) - 1;
            raw = target[31:0];
          end
          default: begin
            offs   = {$urandom(), $urandom()} % 64'(hi_pick - lo_pick + 5);
            target = lo_pick - 2 + longint'(offs);
            raw    = target[31:0];
          end
        endcase
        // Scramble the bits above a sign-extended field
        if (ext_on && raw != noise) raw = (noise & ~fmask) | (raw & fmask);
        send_sample(raw, scale_sample(raw));
      end
    end

    // Drain, then watch for stray results
    drain_results();
    stall_pct <= 0;
    repeat (LATENCY * 4) @(posedge clk);

    $display("covered %0d requests over %0d register writes, %0d results checked",
             requests_sent, register_writes, results_checked);
    $display("input stalled for %0d cycles under backpressure, %0d mismatches",
             input_stall_cycles, mismatches);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- analog_range_scaler.f -----
+incdir+hw/rtl
hw/rtl/ars_pkg.sv
hw/rtl/ars_cfg.sv
hw/rtl/ars_front.sv
hw/rtl/ars_div_stage.sv
hw/rtl/analog_range_scaler.sv
hw/rtl/ars_chk.sv
verif/analog_range_scaler_test.sv
